// ----- hdl/trk_pkg.sv -----
// Shared types and constants for the tapered tank RK4 level emulator.
package trk_pkg;

    // Datapath operations issued by the sequencer.
    typedef enum logic [3:0] {
        OP_SQRT,
        OP_MUL_OUT,
        OP_MUL_RAD,
        OP_MUL_RR,
        OP_MUL_AREA,
        OP_DIV_DER,
        OP_MUL_K,
        OP_APPLY,
        OP_DIV6,
        OP_STORE
    } op_t;

    // RK4 stage index
    localparam logic [1:0] STG_K1 = 2'd0;
    localparam logic [1:0] STG_K2 = 2'd1;
    localparam logic [1:0] STG_K3 = 2'd2;
    localparam logic [1:0] STG_K4 = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSTEPS  = 3'd4;

    // pi scaled by 2^33
    localparam logic [63:0] PI_Q33 = 64'd26986075409;

    typedef struct packed {
        logic       load;
        logic       start;
        op_t        op;
        logic [1:0] stage;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic out_full;
    } dp_stat_t;

endpackage

// ----- hdl/trk_ctrl.sv -----
// Sequencer: walks the RK4 substeps and issues datapath operations.
module trk_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        substeps,
    input  trk_pkg::dp_stat_t stat,
    output trk_pkg::dp_cmd_t  cmd
);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} state_t;

    state_t         state_reg, state_next;
    trk_pkg::op_t   op_reg, op_next;
    logic [1:0]     stage_reg, stage_next;
    logic [7:0]     sub_reg, sub_next;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        stage_next = stage_reg;
        sub_next   = sub_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    sub_next   = substeps;
                    stage_next = trk_pkg::STG_K1;
                    op_next    = trk_pkg::OP_SQRT;
                    state_next = (substeps == 8'd0) ? S_OUT : S_ISSUE;
                end
            end
            S_ISSUE: state_next = S_WAIT;
            S_WAIT: begin
                if (stat.done) begin
                    state_next = S_ISSUE;
                    case (op_reg)
                        trk_pkg::OP_SQRT:     op_next = trk_pkg::OP_MUL_OUT;
                        trk_pkg::OP_MUL_OUT:  op_next = trk_pkg::OP_MUL_RAD;
                        trk_pkg::OP_MUL_RAD:  op_next = trk_pkg::OP_MUL_RR;
                        trk_pkg::OP_MUL_RR:   op_next = trk_pkg::OP_MUL_AREA;
                        trk_pkg::OP_MUL_AREA: op_next = trk_pkg::OP_DIV_DER;
                        trk_pkg::OP_DIV_DER:  op_next = trk_pkg::OP_MUL_K;
                        trk_pkg::OP_MUL_K:    op_next = trk_pkg::OP_APPLY;
                        trk_pkg::OP_APPLY: begin
                            if (stage_reg == trk_pkg::STG_K4) begin
                                op_next = trk_pkg::OP_DIV6;
                            end else begin
                                stage_next = stage_reg + 2'd1;
                                op_next    = trk_pkg::OP_SQRT;
                            end
                        end
                        trk_pkg::OP_DIV6: begin
                            if (sub_reg == 8'd1) begin
                                state_next = S_OUT;
                            end else begin
                                sub_next   = sub_reg - 8'd1;
                                stage_next = trk_pkg::STG_K1;
                                op_next    = trk_pkg::OP_SQRT;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_OUT: begin
                if (!stat.out_full) begin
                    op_next    = trk_pkg::OP_STORE;
                    state_next = S_ISSUE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= trk_pkg::OP_SQRT;
            stage_reg <= trk_pkg::STG_K1;
            sub_reg   <= 8'd0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            stage_reg <= stage_next;
            sub_reg   <= sub_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd.load  = s_valid && (state_reg == S_IDLE);
        cmd.start = (state_reg == S_ISSUE);
        cmd.op    = op_reg;
        cmd.stage = stage_reg;
    end

endmodule

// ----- hdl/trk_dp.sv -----
// Datapath: state registers, serial multiplier, square root and divider.
module trk_dp #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  trk_pkg::dp_cmd_t  cmd,
    output trk_pkg::dp_stat_t stat,
    input  logic [31:0]       s_inflow,
    input  logic [20:0]       cfg_cv,
    input  logic [22:0]       cfg_r0,
    input  logic [16:0]       cfg_alpha,
    input  logic [24:0]       cfg_step,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_level
);

    localparam int W    = VALUE_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int SW   = W + 4;
    localparam int NSQ  = (W + F + 1) / 2;
    localparam int XW   = 2 * NSQ;
    localparam int RW   = NSQ + 3;
    localparam int AW0  = (W > F + 2) ? W : F + 2;
    localparam int AW   = (AW0 > NSQ) ? AW0 : NSQ;
    localparam int PW   = AW + W;
    localparam int DW   = W + F + 3;
    localparam int CNTW = $clog2(DW + 1);
    localparam int SL16 = (F >= 16) ? F - 16 : 0;
    localparam int SR16 = (F >= 16) ? 0 : 16 - F;
    localparam int SL24 = (F >= 24) ? F - 24 : 0;
    localparam int SR24 = (F >= 24) ? 0 : 24 - F;

    // divide by six: multiply by a rounded-up reciprocal, 16 bits of it per cycle
    localparam int AXW  = W + 3;
    localparam int RB   = W + 6;
    localparam int NCH  = (W + 4 + 15) / 16;
    localparam int RCW  = 16 * NCH;
    localparam int PRW  = AXW + RCW;
    localparam int PPW  = AXW + 16;
    localparam logic [63:0] RCP6 = ((64'd1 << RB) + 64'd5) / 64'd6;

    localparam logic [63:0]   MAXV64 = (64'd1 << W) - 64'd1;
    localparam logic [W-1:0]  MAXV   = MAXV64[W-1:0];
    localparam logic signed [SW-1:0] MAXV_S = $signed({4'b0000, MAXV});
    localparam logic [63:0]   PI_Q   = ((trk_pkg::PI_Q33 >> (32 - F)) + 64'd1) >> 1;
    localparam logic [AW-1:0] PI_A   = PI_Q[AW-1:0];

    function automatic logic [W-1:0] sat_u(input logic [63:0] v);
        sat_u = (v > MAXV64) ? MAXV : v[W-1:0];
    endfunction

    function automatic logic signed [SW-1:0] sat_s(input logic signed [SW-1:0] x);
        if (x > MAXV_S) begin
            sat_s = MAXV_S;
        end else if (x < -MAXV_S) begin
            sat_s = -MAXV_S;
        end else begin
            sat_s = x;
        end
    endfunction

    function automatic logic [SW-1:0] mag_f(input logic signed [SW-1:0] x);
        mag_f = x[SW-1] ? $unsigned(-x) : $unsigned(x);
    endfunction

    // configuration in internal format
    logic [W-1:0] cv_q, r0_q, alpha_q, st_q, qin_q;
    assign cv_q    = sat_u((64'(cfg_cv) << SL16) >> SR16);
    assign r0_q    = sat_u((64'(cfg_r0) << SL16) >> SR16);
    assign alpha_q = sat_u((64'(cfg_alpha) << SL16) >> SR16);
    assign st_q    = sat_u((64'(cfg_step) << SL24) >> SR24);
    assign qin_q   = sat_u((64'(s_inflow) << SL16) >> SR16);

    // control registers
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            m_valid_reg, m_valid_next;
    trk_pkg::op_t    op_reg, op_next;
    logic [1:0]      stage_reg, stage_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]    h_reg, h_next;

    // payload registers
    logic signed [SW-1:0] hn_reg, hn_next, hs_reg, hs_next, acc_reg, acc_next;
    logic signed [SW-1:0] num_reg, num_next, rad_reg, rad_next;
    logic signed [SW-1:0] dv_reg, dv_next, k_reg, k_next;
    logic [W-1:0]   qin_reg, qin_next, st_reg, st_next;
    logic [W-1:0]   rr_reg, rr_next, area_reg, area_next;
    logic [NSQ-1:0] sq_reg, sq_next;
    logic [31:0]    m_level_reg, m_level_next;

    logic [PW-1:0]  mul_a_reg, mul_a_next, mul_p_reg, mul_p_next;
    logic [W-1:0]   mul_b_reg, mul_b_next;
    logic           mul_neg_reg, mul_neg_next;
    logic [XW-1:0]  sq_x_reg, sq_x_next;
    logic [RW-1:0]  sq_rem_reg, sq_rem_next;
    logic [NSQ-1:0] sq_root_reg, sq_root_next;
    logic [DW-1:0]  dv_q_reg, dv_q_next;
    logic [W-1:0]   dv_r_reg, dv_r_next, dv_d_reg, dv_d_next;
    logic           dv_neg_reg, dv_neg_next;
    logic [AXW-1:0] d6_a_reg, d6_a_next;
    logic [RCW-1:0] d6_m_reg, d6_m_next;
    logic [PRW-1:0] d6_p_reg, d6_p_next;
    logic           d6_neg_reg, d6_neg_next;

    // helpers
    logic [SW-1:0] hs_mag, rad_mag, dv_mag, num_mag, acc_mag;
    assign hs_mag  = mag_f(hs_reg);
    assign rad_mag = mag_f(rad_reg);
    assign dv_mag  = mag_f(dv_reg);
    assign num_mag = mag_f(num_reg);
    assign acc_mag = mag_f(acc_reg);

    logic [W-1:0] hc, hp;
    assign hc = hs_reg[SW-1] ? '0 : hs_reg[W-1:0];
    assign hp = hn_reg[SW-1] ? '0 : hn_reg[W-1:0];

    logic [63:0] hp_ext;
    logic [31:0] level_sat;
    assign hp_ext    = 64'(hp);
    assign level_sat = (hp_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : hp_ext[31:0];

    // product after scaling, saturated
    logic [PW-1:0]        mul_sh, mul_sum;
    logic [W-1:0]         mres;
    logic signed [SW-1:0] mres_s;
    assign mul_sh  = mul_p_reg >> F;
    assign mul_sum = mul_p_reg + mul_a_reg;
    assign mres    = (mul_sh > PW'(MAXV)) ? MAXV : mul_sh[W-1:0];
    assign mres_s  = mul_neg_reg ? -$signed({4'b0000, mres}) : $signed({4'b0000, mres});

    // restoring divider step
    logic [W:0]           dv_r2, dv_diff;
    logic                 dv_ge;
    logic [W-1:0]         dq_sat;
    logic signed [SW-1:0] dq_s;
    assign dv_r2   = {dv_r_reg, dv_q_reg[DW-1]};
    assign dv_diff = dv_r2 - {1'b0, dv_d_reg};
    assign dv_ge   = (dv_r2 >= {1'b0, dv_d_reg});
    assign dq_sat  = (dv_q_reg > DW'(MAXV)) ? MAXV : dv_q_reg[W-1:0];
    assign dq_s    = dv_neg_reg ? -$signed({4'b0000, dq_sat}) : $signed({4'b0000, dq_sat});

    // weighted sum over six, top reciprocal digit first
    logic [PPW-1:0]       d6_pp;
    logic [PRW-1:0]       d6_q;
    logic [W-1:0]         d6_sat;
    logic signed [SW-1:0] d6_s;
    assign d6_pp  = PPW'(d6_a_reg) * PPW'(d6_m_reg[RCW-1 -: 16]);
    assign d6_q   = d6_p_reg >> RB;
    assign d6_sat = (d6_q > PRW'(MAXV)) ? MAXV : d6_q[W-1:0];
    assign d6_s   = d6_neg_reg ? -$signed({4'b0000, d6_sat}) : $signed({4'b0000, d6_sat});

    // square root step, two radicand bits per cycle
    logic [RW-1:0] sq_rem2, sq_trial;
    logic          sq_ge;
    assign sq_rem2  = {sq_rem_reg[RW-3:0], sq_x_reg[XW-1 -: 2]};
    assign sq_trial = RW'({sq_root_reg, 2'b01});
    assign sq_ge    = (sq_rem2 >= sq_trial);

    // k/2 toward zero
    logic signed [SW-1:0] k_half;
    assign k_half = (k_reg + $signed({{(SW-1){1'b0}}, k_reg[SW-1]})) >>> 1;

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        op_next      = op_reg;
        stage_next   = stage_reg;
        cnt_next     = cnt_reg;
        h_next       = h_reg;
        hn_next      = hn_reg;
        hs_next      = hs_reg;
        acc_next     = acc_reg;
        num_next     = num_reg;
        rad_next     = rad_reg;
        dv_next      = dv_reg;
        k_next       = k_reg;
        qin_next     = qin_reg;
        st_next      = st_reg;
        rr_next      = rr_reg;
        area_next    = area_reg;
        sq_next      = sq_reg;
        m_level_next = m_level_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        mul_p_next   = mul_p_reg;
        mul_neg_next = mul_neg_reg;
        sq_x_next    = sq_x_reg;
        sq_rem_next  = sq_rem_reg;
        sq_root_next = sq_root_reg;
        dv_q_next    = dv_q_reg;
        dv_r_next    = dv_r_reg;
        dv_d_next    = dv_d_reg;
        dv_neg_next  = dv_neg_reg;
        d6_a_next    = d6_a_reg;
        d6_m_next    = d6_m_reg;
        d6_p_next    = d6_p_reg;
        d6_neg_next  = d6_neg_reg;

        if (cmd.load) begin
            hn_next  = $signed({4'b0000, h_reg});
            hs_next  = $signed({4'b0000, h_reg});
            qin_next = qin_q;
            st_next  = st_q;
        end

        if (cmd.start) begin
            op_next      = cmd.op;
            stage_next   = cmd.stage;
            busy_next    = 1'b1;
            cnt_next     = '0;
            mul_p_next   = '0;
            mul_neg_next = 1'b0;
            case (cmd.op)
                trk_pkg::OP_SQRT: begin
                    sq_x_next    = XW'(hc) << F;
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    cnt_next     = CNTW'(NSQ);
                end
                trk_pkg::OP_MUL_OUT: begin
                    mul_a_next = PW'(sq_reg);
                    mul_b_next = cv_q;
                    cnt_next   = CNTW'(W);
                end
                trk_pkg::OP_MUL_RAD: begin
                    mul_a_next   = PW'(hs_mag[W-1:0]);
                    mul_b_next   = alpha_q;
                    mul_neg_next = hs_reg[SW-1];
                    cnt_next     = CNTW'(W);
                end
                trk_pkg::OP_MUL_RR: begin
                    mul_a_next = PW'(rad_mag[W-1:0]);
                    mul_b_next = rad_mag[W-1:0];
                    cnt_next   = CNTW'(W);
                end
                trk_pkg::OP_MUL_AREA: begin
                    mul_a_next = PW'(PI_A);
                    mul_b_next = rr_reg;
                    cnt_next   = CNTW'(W);
                end
                trk_pkg::OP_MUL_K: begin
                    mul_a_next   = PW'(dv_mag[W-1:0]);
                    mul_b_next   = st_reg;
                    mul_neg_next = dv_reg[SW-1];
                    cnt_next     = CNTW'(W);
                end
                trk_pkg::OP_DIV_DER: begin
                    dv_q_next   = DW'(num_mag[W-1:0]) << F;
                    dv_r_next   = '0;
                    dv_d_next   = area_reg;
                    dv_neg_next = num_reg[SW-1];
                    cnt_next    = CNTW'(DW);
                end
                trk_pkg::OP_DIV6: begin
                    d6_a_next   = acc_mag[W+2:0];
                    d6_m_next   = RCP6[RCW-1:0];
                    d6_p_next   = '0;
                    d6_neg_next = acc_reg[SW-1];
                    cnt_next    = CNTW'(NCH);
                end
                default: ;
            endcase
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                cnt_next = cnt_reg - CNTW'(1);
                case (op_reg)
                    trk_pkg::OP_MUL_OUT, trk_pkg::OP_MUL_RAD, trk_pkg::OP_MUL_RR,
                    trk_pkg::OP_MUL_AREA, trk_pkg::OP_MUL_K: begin
                        if (mul_b_reg[0]) begin
                            mul_p_next = mul_sum;
                        end
                        mul_a_next = mul_a_reg << 1;
                        mul_b_next = mul_b_reg >> 1;
                    end
                    trk_pkg::OP_SQRT: begin
                        sq_x_next = sq_x_reg << 2;
                        if (sq_ge) begin
                            sq_rem_next  = sq_rem2 - sq_trial;
                            sq_root_next = {sq_root_reg[NSQ-2:0], 1'b1};
                        end else begin
                            sq_rem_next  = sq_rem2;
                            sq_root_next = {sq_root_reg[NSQ-2:0], 1'b0};
                        end
                    end
                    trk_pkg::OP_DIV_DER: begin
                        dv_r_next = dv_ge ? dv_diff[W-1:0] : dv_r2[W-1:0];
                        dv_q_next = {dv_q_reg[DW-2:0], dv_ge};
                    end
                    trk_pkg::OP_DIV6: begin
                        d6_p_next = (d6_p_reg << 16) + PRW'(d6_pp);
                        d6_m_next = d6_m_reg << 16;
                    end
                    default: ;
                endcase
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
                case (op_reg)
                    trk_pkg::OP_SQRT:    sq_next  = sq_root_reg;
                    trk_pkg::OP_MUL_OUT: num_next = $signed({4'b0000, qin_reg}) - mres_s;
                    trk_pkg::OP_MUL_RAD: rad_next = sat_s($signed({4'b0000, r0_q}) + mres_s);
                    trk_pkg::OP_MUL_RR:  rr_next  = mres;
                    trk_pkg::OP_MUL_AREA: begin
                        // empty tank cross-section: treat area as one lsb
                        area_next = (mres == '0) ? W'(1'b1) : mres;
                    end
                    trk_pkg::OP_DIV_DER: dv_next = dq_s;
                    trk_pkg::OP_MUL_K:   k_next  = mres_s;
                    trk_pkg::OP_APPLY: begin
                        case (stage_reg)
                            trk_pkg::STG_K1: begin
                                acc_next = k_reg;
                                hs_next  = sat_s(hn_reg + k_half);
                            end
                            trk_pkg::STG_K2: begin
                                acc_next = acc_reg + (k_reg <<< 1);
                                hs_next  = sat_s(hn_reg + k_half);
                            end
                            trk_pkg::STG_K3: begin
                                acc_next = acc_reg + (k_reg <<< 1);
                                hs_next  = sat_s(hn_reg + k_reg);
                            end
                            default: acc_next = acc_reg + k_reg;
                        endcase
                    end
                    trk_pkg::OP_DIV6: begin
                        hn_next = sat_s(hn_reg + d6_s);
                        hs_next = sat_s(hn_reg + d6_s);
                    end
                    trk_pkg::OP_STORE: begin
                        h_next       = hp;
                        m_level_next = level_sat;
                        m_valid_next = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            op_reg      <= trk_pkg::OP_SQRT;
            stage_reg   <= trk_pkg::STG_K1;
            cnt_reg     <= '0;
            h_reg       <= '0;
        end else begin
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
            op_reg      <= op_next;
            stage_reg   <= stage_next;
            cnt_reg     <= cnt_next;
            h_reg       <= h_next;
        end
    end

    always_ff @(posedge aclk) begin
        hn_reg      <= hn_next;
        hs_reg      <= hs_next;
        acc_reg     <= acc_next;
        num_reg     <= num_next;
        rad_reg     <= rad_next;
        dv_reg      <= dv_next;
        k_reg       <= k_next;
        qin_reg     <= qin_next;
        st_reg      <= st_next;
        rr_reg      <= rr_next;
        area_reg    <= area_next;
        sq_reg      <= sq_next;
        m_level_reg <= m_level_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        mul_p_reg   <= mul_p_next;
        mul_neg_reg <= mul_neg_next;
        sq_x_reg    <= sq_x_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        dv_q_reg    <= dv_q_next;
        dv_r_reg    <= dv_r_next;
        dv_d_reg    <= dv_d_next;
        dv_neg_reg  <= dv_neg_next;
        d6_a_reg    <= d6_a_next;
        d6_m_reg    <= d6_m_next;
        d6_p_reg    <= d6_p_next;
        d6_neg_reg  <= d6_neg_next;
    end

    assign stat.done     = done_reg;
    assign stat.out_full = m_valid_reg && !m_ready;
    assign m_valid       = m_valid_reg;
    assign m_level       = m_level_reg;

endmodule

// ----- hdl/tank_level_rk4_step.sv -----
// Top level of the tapered tank RK4 level emulator: config registers and core.
//
// Each input beat carries one control period's inflow; the block runs `substeps`
// RK4 substeps on the stored height and returns one level beat, 20 substeps by
// default. One derivative evaluation is a bit-serial square root, five shift-add
// multiplies and a restoring divide, plus issue overhead; a substep is four
// evaluations plus a divide by six, done as a reciprocal multiply 16 bits per
// cycle. One beat is worked at a time; the next is accepted while the previous
// result waits in the output register.
module tank_level_rk4_step #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [trk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trk_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [31:0]                      s_inflow,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [31:0]                      m_level
);

    logic [20:0] cv_reg;
    logic [22:0] r0_reg;
    logic [16:0] alpha_reg;
    logic [24:0] step_reg;
    logic [7:0]  substeps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg       <= 21'd65536;
            r0_reg       <= 23'd655360;
            alpha_reg    <= 17'd5243;
            step_reg     <= 25'd83886;
            substeps_reg <= 8'd20;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                trk_pkg::CFG_DISCHARGE: cv_reg       <= cfg_data[20:0];
                trk_pkg::CFG_RADIUS:    r0_reg       <= cfg_data[22:0];
                trk_pkg::CFG_TAPER:     alpha_reg    <= cfg_data[16:0];
                trk_pkg::CFG_STEP:      step_reg     <= cfg_data[24:0];
                trk_pkg::CFG_SUBSTEPS:  substeps_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    trk_pkg::dp_cmd_t  cmd;
    trk_pkg::dp_stat_t stat;

    trk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .substeps (substeps_reg),
        .stat     (stat),
        .cmd      (cmd)
    );

    trk_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_inflow  (s_inflow),
        .cfg_cv    (cv_reg),
        .cfg_r0    (r0_reg),
        .cfg_alpha (alpha_reg),
        .cfg_step  (step_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_level   (m_level)
    );

endmodule
